// ===== src/lpht_pkg.sv =====
package lpht_pkg;

   localparam int TableSlotsDefault  = 1024;
   localparam int KeyBytesMaxDefault = 8;

   localparam logic [63:0] FnvBasis = 64'hCBF29CE484222325;
   localparam logic [63:0] FnvMult  = 64'h00000100000001B3;

   localparam logic [1:0] OP_GET    = 2'd0;
   localparam logic [1:0] OP_SET    = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [2:0] ST_HIT      = 3'd0;
   localparam logic [2:0] ST_MISS     = 3'd1;
   localparam logic [2:0] ST_INSERTED = 3'd2;
   localparam logic [2:0] ST_UPDATED  = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_REMOVED  = 3'd5;
   localparam logic [2:0] ST_ABSENT   = 3'd6;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] key_bytes;
      logic [3:0]  key_length;
      logic [63:0] new_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] read_value;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, start hash
      logic hash_step;  // half of one FNV byte round
      logic set_home;   // probe position from hash
      logic read;       // issue slot read at probe position
      logic advance;    // step probe position, count slot
      logic note_tomb;  // remember current position as first tombstone
      logic wr_value;   // write value at probe position
      logic wr_tomb;    // mark tombstone at probe position
      logic insert;     // write key/value at chosen free slot
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       clearing;
      logic       hash_done;
      logic       used;
      logic       tomb;
      logic       match;
      logic       all_seen;
      logic       have_tomb;
      logic [1:0] opcode;
   } sts_type;

endpackage

// ===== src/lpht_datapath.sv =====
module lpht_datapath #(
   parameter int TABLE_SLOTS   = lpht_pkg::TableSlotsDefault,
   parameter int KEY_BYTES_MAX = lpht_pkg::KeyBytesMaxDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  lpht_pkg::req_type req,
   input  lpht_pkg::cmd_type cmd,
   output lpht_pkg::sts_type sts,
   output logic [63:0]       value_out
);
   import lpht_pkg::*;

   localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam logic [3:0] LenMax = 4'(KEY_BYTES_MAX);

   logic [1:0]    op_ff;
   logic [63:0]   key_ff, val_ff, hash_ff, prod_ff;
   logic [3:0]    len_ff, byte_ff;
   logic          mul_ph_ff;
   logic [IW-1:0] pos_ff, tomb_pos_ff;
   logic          have_tomb_ff;
   logic [CW-1:0] seen_ff;

   // slot stores; marks kept as {used, tombstone} and cleared by a pass after reset
   logic [63:0] key_mem [TABLE_SLOTS];
   logic [3:0]  len_mem [TABLE_SLOTS];
   logic [63:0] val_mem [TABLE_SLOTS];
   logic [1:0]  mark_mem [TABLE_SLOTS];
   logic [63:0] rd_key_ff, rd_val_ff;
   logic [3:0]  rd_len_ff;
   logic        rd_used_ff, rd_tomb_ff;
   logic [IW-1:0] clr_ff;
   logic          clearing_ff;

   logic [3:0]  len_sat;
   logic [63:0] key_msk;
   logic [63:0] hx;
   logic [IW-1:0] pos_next, wr_pos;
   logic          mark_we;
   logic [IW-1:0] mark_addr;
   logic [1:0]    mark_data;

   always_comb begin
      len_sat = (req.key_length > LenMax) ? LenMax : req.key_length;
      key_msk = '0;
      for (int i = 0; i < 8; i++)
         if (4'(i) < len_sat) key_msk[i*8 +: 8] = 8'hFF;
      hx = hash_ff ^ {56'd0, key_ff[byte_ff[2:0]*8 +: 8]};
      pos_next = (pos_ff == IW'(TABLE_SLOTS - 1)) ? '0 : pos_ff + 1'b1;
      wr_pos = have_tomb_ff ? tomb_pos_ff : pos_ff;
   end

   // pick the one mark write of this cycle
   always_comb begin
      mark_we = 1'b0;
      mark_addr = pos_ff;
      mark_data = 2'b00;
      if (clearing_ff) begin
         mark_we = 1'b1;
         mark_addr = clr_ff;
      end else if (cmd.insert) begin
         mark_we = 1'b1;
         mark_addr = wr_pos;
         mark_data = 2'b10;
      end else if (cmd.wr_tomb) begin
         mark_we = 1'b1;
         mark_data = 2'b11;
      end
   end

   // hash: xor byte, multiply in two registered halves
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req.opcode;
         key_ff <= req.key_bytes & key_msk;
         len_ff <= len_sat;
         val_ff <= req.new_value;
         hash_ff <= FnvBasis;
         byte_ff <= '0;
         mul_ph_ff <= 1'b0;
      end else if (cmd.hash_step) begin
         if (!mul_ph_ff) prod_ff <= hx[31:0] * FnvMult[31:0];
         else begin
            hash_ff <= prod_ff + {hx[31:0] * FnvMult[63:32], 32'd0}
                       + {hx[63:32] * FnvMult[31:0], 32'd0};
            byte_ff <= byte_ff + 1'b1;
         end
         mul_ph_ff <= ~mul_ph_ff;
      end
   end

   // probe position and tombstone tracking; home is the low hash bits
   always_ff @(posedge clock) begin
      if (cmd.set_home) begin
         pos_ff <= hash_ff[IW-1:0];
         seen_ff <= '0;
         have_tomb_ff <= 1'b0;
      end else begin
         if (cmd.advance) begin
            pos_ff <= pos_next;
            seen_ff <= seen_ff + 1'b1;
         end
         if (cmd.note_tomb && !have_tomb_ff) begin
            have_tomb_ff <= 1'b1;
            tomb_pos_ff <= pos_ff;
         end
      end
   end

   // memory read and write
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_key_ff <= key_mem[pos_ff];
         rd_len_ff <= len_mem[pos_ff];
         rd_val_ff <= val_mem[pos_ff];
      end
      if (cmd.wr_value) val_mem[pos_ff] <= val_ff;
      if (cmd.insert) begin
         key_mem[wr_pos] <= key_ff;
         len_mem[wr_pos] <= len_ff;
         val_mem[wr_pos] <= val_ff;
      end
   end

   // walk every slot once after reset, clearing its marks
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff <= '0;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == IW'(TABLE_SLOTS - 1)) clearing_ff <= 1'b0;
      end
   end

   // mark store
   always_ff @(posedge clock) begin
      if (mark_we) mark_mem[mark_addr] <= mark_data;
      if (cmd.read) {rd_used_ff, rd_tomb_ff} <= mark_mem[pos_ff];
   end

   assign sts.clearing  = clearing_ff;
   assign sts.hash_done = (byte_ff >= len_ff);
   assign sts.used      = rd_used_ff;
   assign sts.tomb      = rd_tomb_ff;
   assign sts.match     = (rd_len_ff == len_ff) && (rd_key_ff == key_ff);
   assign sts.all_seen  = (seen_ff == CW'(TABLE_SLOTS));
   assign sts.have_tomb = have_tomb_ff;
   assign sts.opcode    = op_ff;
   assign value_out     = rd_val_ff;

endmodule

// ===== src/lpht_control.sv =====
module lpht_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lpht_pkg::sts_type sts,
   input  logic [63:0]       value_in,
   output lpht_pkg::cmd_type cmd,
   output logic              rsp_valid,
   output lpht_pkg::rsp_type rsp
);
   import lpht_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HASH  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_HOME  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      rsp_in = rsp_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               cmd.load = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (sts.opcode == OP_NONE) begin
               rsp_in = '{ST_MISS, 64'd0};
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else if (sts.hash_done) begin
               state_in = S_HOME;
            end else begin
               cmd.hash_step = 1'b1;
            end
         end
         S_HOME: begin
            cmd.set_home = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            if (sts.all_seen) begin
               valid_in = 1'b1;
               rsp_in.read_value = '0;
               if (sts.opcode == OP_SET) begin
                  if (sts.have_tomb) begin
                     cmd.insert = 1'b1;
                     rsp_in.status = ST_INSERTED;
                  end else rsp_in.status = ST_FULL;
               end else
                  rsp_in.status = (sts.opcode == OP_GET) ? ST_MISS : ST_ABSENT;
               state_in = S_IDLE;
            end else begin
               cmd.read = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            valid_in = 1'b1;
            rsp_in.read_value = '0;
            state_in = S_IDLE;
            if (!sts.used) begin
               if (sts.opcode == OP_SET) begin
                  cmd.insert = 1'b1;
                  rsp_in.status = ST_INSERTED;
               end else
                  rsp_in.status = (sts.opcode == OP_GET) ? ST_MISS : ST_ABSENT;
            end else if (!sts.tomb && sts.match) begin
               case (sts.opcode)
                  OP_GET: begin
                     rsp_in.status = ST_HIT;
                     rsp_in.read_value = value_in;
                  end
                  OP_SET: begin
                     cmd.wr_value = 1'b1;
                     rsp_in.status = ST_UPDATED;
                  end
                  default: begin
                     cmd.wr_tomb = 1'b1;
                     rsp_in.status = ST_REMOVED;
                  end
               endcase
            end else begin
               // skip: note tombstone, move on
               valid_in = 1'b0;
               cmd.note_tomb = sts.tomb;
               cmd.advance = 1'b1;
               state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE) || valid_ff || sts.clearing;
   assign rsp_valid = valid_ff;
   assign rsp = rsp_ff;

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.insert, cmd.wr_value, cmd.wr_tomb}) <= 1)
      else $error("more than one slot write");
   a_resp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_IDLE)
      else $error("response while walking");
   a_no_hit_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != ST_HIT |-> rsp.read_value == 64'd0)
      else $error("value on non-hit");

endmodule

// ===== src/linear_probe_hash_table_top.sv =====
// Key-value table: one response per request, strobed by rsp_valid for one cycle;
// the receiver cannot stall. After reset busy stays high while a pass clears
// the slot marks. The key length is saturated at KEY_BYTES_MAX. A request
// hashes its valid key bytes with FNV-1a (a 64-bit multiply split into
// registered halves), finishes the hash, loads the home slot, then probes
// slot by slot (registered slot read, then compare). A set that walks every
// slot without finding room answers full; opcode three answers straight from
// the hash state. busy stays high until the response has been shown. The
// home slot is the low hash bits, so TABLE_SLOTS must be a power of two.
module linear_probe_hash_table_top #(
   parameter int TABLE_SLOTS   = lpht_pkg::TableSlotsDefault,
   parameter int KEY_BYTES_MAX = lpht_pkg::KeyBytesMaxDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lpht_pkg::req_type req_data,
   output logic              rsp_valid,
   output lpht_pkg::rsp_type rsp_data
);
   import lpht_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [63:0] value;

   lpht_control u_control (
      .clock, .reset, .start, .busy, .sts, .value_in(value), .cmd,
      .rsp_valid, .rsp(rsp_data)
   );

   lpht_datapath #(.TABLE_SLOTS(TABLE_SLOTS), .KEY_BYTES_MAX(KEY_BYTES_MAX)) u_datapath (
      .clock, .reset, .req(req_data), .cmd, .sts, .value_out(value)
   );

endmodule

// ===== dv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lpht_pkg::*;

   localparam int Slots = 1024;
   localparam longint CycleLimit = 64'd10000000;

   // software image of the slot store, with one expected-response queue
   class table_scoreboard;
      logic [63:0] key_store[Slots];
      logic [3:0]  len_store[Slots];
      logic [63:0] value_store[Slots];
      bit          used_mark[Slots];
      bit          tomb_mark[Slots];
      rsp_type     pending_rsp[$];
      int          error_count;

      function new();
         for (int i = 0; i < Slots; i++) begin
            used_mark[i] = 0;
            tomb_mark[i] = 0;
            key_store[i] = '0;
            len_store[i] = '0;
            value_store[i] = '0;
         end
         error_count = 0;
      endfunction

      // predict the response for one accepted request and update the image
      function void note_request(req_type rq);
         logic [3:0]  klen;
         logic [63:0] kmask, kval, hsh;
         int          pos, tpos;
         bit          have_t, done;
         rsp_type     rs;
         klen = (rq.key_length > 4'd8) ? 4'd8 : rq.key_length;
         kmask = (klen == 4'd8) ? '1 : ((64'd1 << (8 * klen)) - 64'd1);
         kval = rq.key_bytes & kmask;
         rs.read_value = '0;
         done = 0;
         have_t = 0;
         tpos = 0;
         if (rq.opcode == OP_NONE) begin
            rs.status = ST_MISS;
            pending_rsp.push_back(rs);
            return;
         end
         hsh = FnvBasis;
         for (int i = 0; i < klen; i++) hsh = (hsh ^ ((kval >> (8 * i)) & 64'hFF)) * FnvMult;
         pos = int'(hsh % Slots);
         rs.status = (rq.opcode == OP_GET) ? ST_MISS : (rq.opcode == OP_SET) ? ST_FULL : ST_ABSENT;
         for (int n = 0; n < Slots && !done; n++) begin
            if (!used_mark[pos]) begin
               if (rq.opcode == OP_SET) begin
                  if (!have_t) tpos = pos;
                  have_t = 1;
               end
               done = 1;
            end else if (tomb_mark[pos]) begin
               if (!have_t) tpos = pos;
               have_t = 1;
            end else if (len_store[pos] == klen && key_store[pos] == kval) begin
               if (rq.opcode == OP_GET) begin
                  rs.status = ST_HIT;
                  rs.read_value = value_store[pos];
               end else if (rq.opcode == OP_SET) begin
                  value_store[pos] = rq.new_value;
                  rs.status = ST_UPDATED;
               end else begin
                  tomb_mark[pos] = 1;
                  rs.status = ST_REMOVED;
               end
               pending_rsp.push_back(rs);
               return;
            end
            if (!done) pos = (pos + 1) % Slots;
         end
         if (rq.opcode == OP_SET && have_t) begin
            key_store[tpos] = kval;
            len_store[tpos] = klen;
            value_store[tpos] = rq.new_value;
            used_mark[tpos] = 1;
            tomb_mark[tpos] = 0;
            rs.status = ST_INSERTED;
         end
         pending_rsp.push_back(rs);
      endfunction

      // compare one strobed response with the oldest prediction
      function void check_response(rsp_type got);
         rsp_type exp_rsp;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response status=%0d read_value=%h", got.status, got.read_value);
            error_count++;
            return;
         end
         exp_rsp = pending_rsp.pop_front();
         if (got.status !== exp_rsp.status) begin
            $error("status expected %0d actual %0d", exp_rsp.status, got.status);
            error_count++;
         end
         if (got.read_value !== exp_rsp.read_value) begin
            $error("read_value expected %h actual %h", exp_rsp.read_value, got.read_value);
            error_count++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   longint  cycle_count = 0;
   int      idle_pct = 0;
   logic [63:0] key_pool[16];
   logic [3:0]  klen_pool[16];
   table_scoreboard sb = new();

   linear_probe_hash_table_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // sample responses and bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) sb.check_response(rsp_data);
      if (cycle_count > CycleLimit) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // issue one request; hold start until it is accepted, leave it to the next caller
   task automatic send_request(logic [1:0] op, logic [63:0] kb, logic [3:0] kl, logic [63:0] nv);
      req_type rq;
      rq.opcode = op;
      rq.key_bytes = kb;
      rq.key_length = kl;
      rq.new_value = nv;
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(rq);
   endtask

   task automatic drain();
      start <= 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // pick a key from the small pool so that hits, updates and removals happen
   task automatic random_request();
      int          k;
      logic [1:0]  op;
      logic [63:0] junk;
      k = $urandom_range(15);
      op = logic'($urandom_range(99) < 3) ? OP_NONE : 2'($urandom_range(2));
      junk = {$urandom, $urandom};
      if ($urandom_range(9) == 0)
         send_request(op, junk, 4'($urandom_range(15)), {$urandom, $urandom});
      else
         send_request(op, key_pool[k] | (junk << (8 * klen_pool[k])) & {64{klen_pool[k] < 8}},
                      klen_pool[k], {$urandom, $urandom});
   endtask

   initial begin
      for (int i = 0; i < 16; i++) begin
         key_pool[i] = {$urandom, $urandom};
         klen_pool[i] = 4'($urandom_range(8, 1));
         if (klen_pool[i] < 8) key_pool[i] &= (64'd1 << (8 * klen_pool[i])) - 1;
      end
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: every opcode, field extremes, length zero and above maximum
      send_request(OP_GET, 64'h0, 4'd1, 64'h0);
      send_request(OP_DELETE, 64'h0, 4'd1, 64'h0);
      send_request(OP_SET, 64'h0, 4'd1, '1);
      send_request(OP_GET, 64'hFF00, 4'd1, 64'h0);
      send_request(OP_SET, 64'h0, 4'd1, 64'h5);
      send_request(OP_SET, '1, 4'd8, '1);
      send_request(OP_GET, '1, 4'd15, 64'h0);
      send_request(OP_SET, 64'h41, 4'd0, 64'h1234);
      send_request(OP_GET, 64'h0, 4'd0, 64'h0);
      send_request(OP_NONE, '1, 4'd8, '1);
      send_request(OP_DELETE, 64'h0, 4'd1, 64'h0);
      send_request(OP_GET, 64'h0, 4'd1, 64'h0);
      send_request(OP_DELETE, 64'h0, 4'd1, 64'h0);
      send_request(OP_SET, 64'h0, 4'd1, 64'h9);
      send_request(OP_GET, 64'h0, 4'd1, 64'h0);
      send_request(OP_SET, 64'h6261, 4'd2, 64'hAA);
      send_request(OP_GET, 64'h6261, 4'd3, 64'h0);
      send_request(OP_DELETE, '1, 4'd8, 64'h0);

      // random phases with varying sender idling
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 70 : (ph == 3) ? 7 : 0;
         for (int i = 0; i < 210; i++) random_request();
         drain();
      end
      idle_pct = 0;
      for (int i = 0; i < 10; i++) random_request();
      drain();
      if (sb.error_count == 0 && sb.pending_rsp.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
